>>> hdl/keyboard_control_conditioner_core_macros.svh
// Assertion macros used by the port checker of the keyboard control conditioner.
// Depends on nothing; the user supplies clock, reset and the property terms.
`ifndef KEYBOARD_CONTROL_CONDITIONER_CORE_MACROS_SVH
`define KEYBOARD_CONTROL_CONDITIONER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kcc port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kcc port check failed");

`endif

>>> hdl/kcc_pkg.sv
// Shared types and constants of the keyboard control conditioner.
// Used by the top level, the octave picker and the port checker; depends on nothing.
package kcc_pkg;

    localparam int NUM_KEYS_DEFAULT = 13;
    localparam int KEY_IDX_W        = 4;
    localparam int REQ_W            = 3;
    localparam int ARG_W            = 8;
    localparam int LEVEL_W          = 10;
    localparam int FLAG_W           = 4;
    localparam int OCT_W            = 2;

    localparam int LEVEL_MAX  = 1023;
    localparam int OCT_CENTER = 128;

    localparam logic [ARG_W-1:0] HYST_GAP_RESET = 8'd32;

    // Change-flag bit positions.
    localparam int FLG_KEY   = 0;
    localparam int FLG_PRESS = 1;
    localparam int FLG_INPUT = 2;
    localparam int FLG_RANGE = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_KEY   = 3'd0,
        REQ_PRESS = 3'd1,
        REQ_INPUT = 3'd2,
        REQ_RANGE = 3'd3,
        REQ_CLEAR = 3'd4
    } kcc_req_t;

endpackage

>>> hdl/kcc_octave_pick.sv
// Octave selection with hysteresis for the keyboard control conditioner.
// Depends on kcc_pkg for widths and constants.
module kcc_octave_pick
    import kcc_pkg::*;
(
    input  logic [LEVEL_W-1:0] range_level,
    input  logic [OCT_W-1:0]   octave_cur,
    input  logic [ARG_W-1:0]   gap,
    output logic [OCT_W-1:0]   octave_new
);

    logic [LEVEL_W-1:0] inv_level;
    logic [LEVEL_W-1:0] center;
    logic [LEVEL_W-1:0] gap_ext;
    logic [LEVEL_W:0]   up_sum;
    logic [LEVEL_W-1:0] adj_level;

    // The level is inverted so that a high range reading picks a low octave.
    assign inv_level = ~range_level;
    assign center    = {octave_cur, 8'(OCT_CENTER)};
    assign gap_ext   = {{(LEVEL_W-ARG_W){1'b0}}, gap};
    assign up_sum    = {1'b0, inv_level} + {1'b0, gap_ext};

    always_comb
    begin
        if (inv_level > center)
        begin
            adj_level = (inv_level > gap_ext) ? (inv_level - gap_ext) : '0;
        end
        else if (inv_level < center)
        begin
            adj_level = (up_sum > (LEVEL_W+1)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                           : up_sum[LEVEL_W-1:0];
        end
        else
        begin
            adj_level = inv_level;
        end
    end

    assign octave_new = adj_level[LEVEL_W-1:LEVEL_W-OCT_W];

endmodule

>>> hdl/keyboard_control_conditioner_core.sv
// Keyboard control conditioner: key map, press value, smoothed samples and octave choice.
// A request beat is held in the request register, then moves into the result registers when it advances.
// Throughput: one request beat per cycle, limited only by result-side stall.
// Reset (rst_n, asynchronous, active low) clears all state but the request payload and sets the gap to 32.
// Depends on kcc_pkg and kcc_octave_pick.
module keyboard_control_conditioner_core
    import kcc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [ARG_W-1:0]     cfg_wr_data,

    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [KEY_IDX_W-1:0] key_index,
    input  logic [ARG_W-1:0]     small_arg,
    input  logic [LEVEL_W-1:0]   sample,

    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [FLAG_W-1:0]    change_flags,
    output logic [NUM_KEYS-1:0]  key_map,
    output logic [ARG_W-1:0]     press_level,
    output logic [LEVEL_W-1:0]   input_level,
    output logic [LEVEL_W-1:0]   range_level,
    output logic [OCT_W-1:0]     octave
);

    // The design has two register ranks. The first holds the request beat as it
    // was taken. The second is the conditioner's own state, which doubles as the
    // result register: the state only moves when a beat advances into the result
    // slot, and a beat can only advance when that slot is free or being taken, so
    // the state always shows exactly the result of the last beat that advanced.

    logic [ARG_W-1:0]     gap_reg;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [REQ_W-1:0]     s1_type_reg;
    logic [KEY_IDX_W-1:0] s1_key_reg;
    logic [ARG_W-1:0]     s1_arg_reg;
    logic [LEVEL_W-1:0]   s1_sample_reg;

    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic [FLAG_W-1:0]    flags_reg;
    logic [FLAG_W-1:0]    flags_next;
    logic [NUM_KEYS-1:0]  map_reg;
    logic [NUM_KEYS-1:0]  map_next;
    logic [ARG_W-1:0]     press_reg;
    logic [ARG_W-1:0]     press_next;
    logic [LEVEL_W-1:0]   input_reg;
    logic [LEVEL_W-1:0]   input_next;
    logic [LEVEL_W-1:0]   range_reg;
    logic [LEVEL_W-1:0]   range_next;
    logic [OCT_W-1:0]     octave_reg;
    logic [OCT_W-1:0]     octave_next;

    logic                 advance;
    logic                 accept;
    logic [NUM_KEYS-1:0]  key_hit;
    logic [NUM_KEYS-1:0]  map_upd;
    logic [LEVEL_W:0]     input_sum;
    logic [LEVEL_W:0]     range_sum;
    logic [LEVEL_W-1:0]   range_avg_new;
    logic [OCT_W-1:0]     octave_pick;

    // Handshake. The held beat advances unless a finished result is still waiting.
    assign advance   = s1_valid_reg && !(res_valid_reg && res_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && res_stall);

    // One-hot key decode; an index at or beyond the key count matches nothing,
    // so such a key event leaves the map and its flag alone.
    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            key_hit[i] = (s1_key_reg == KEY_IDX_W'(i));
        end
    end

    // Pin level low means pressed.
    assign map_upd = s1_arg_reg[0] ? (map_reg & ~key_hit) : (map_reg | key_hit);

    // Averages of the stored and the new sample, truncated.
    assign input_sum     = {1'b0, s1_sample_reg} + {1'b0, input_reg};
    assign range_sum     = {1'b0, s1_sample_reg} + {1'b0, range_reg};
    assign range_avg_new = range_sum[LEVEL_W:1];

    // The octave is re-picked from the freshly smoothed range level.
    kcc_octave_pick u_octave_pick
    (
        .range_level (range_avg_new),
        .octave_cur  (octave_reg),
        .gap         (gap_reg),
        .octave_new  (octave_pick)
    );

    always_comb
    begin
        flags_next  = flags_reg;
        map_next    = map_reg;
        press_next  = press_reg;
        input_next  = input_reg;
        range_next  = range_reg;
        octave_next = octave_reg;
        if (advance)
        begin
            case (s1_type_reg)
                REQ_KEY:
                begin
                    if (map_upd != map_reg)
                    begin
                        map_next           = map_upd;
                        flags_next[FLG_KEY] = 1'b1;
                    end
                end
                REQ_PRESS:
                begin
                    if (press_reg != s1_arg_reg)
                    begin
                        press_next            = s1_arg_reg;
                        flags_next[FLG_PRESS] = 1'b1;
                    end
                end
                REQ_INPUT:
                begin
                    if (input_reg != s1_sample_reg)
                    begin
                        input_next            = input_sum[LEVEL_W:1];
                        flags_next[FLG_INPUT] = 1'b1;
                    end
                end
                REQ_RANGE:
                begin
                    if (range_reg != s1_sample_reg)
                    begin
                        range_next            = range_avg_new;
                        octave_next           = octave_pick;
                        flags_next[FLG_RANGE] = 1'b1;
                    end
                end
                REQ_CLEAR:
                begin
                    // Only the low mask bits name flags.
                    flags_next = flags_reg & ~s1_arg_reg[FLAG_W-1:0];
                end
                default:
                begin
                    // Unknown request kinds still report the current state.
                end
            endcase
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= HYST_GAP_RESET;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            flags_reg     <= '0;
            map_reg       <= '0;
            press_reg     <= '0;
            input_reg     <= '0;
            range_reg     <= '0;
            octave_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gap_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            flags_reg     <= flags_next;
            map_reg       <= map_next;
            press_reg     <= press_next;
            input_reg     <= input_next;
            range_reg     <= range_next;
            octave_reg    <= octave_next;
        end
    end

    // Request payload capture; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg   <= req_type;
            s1_key_reg    <= key_index;
            s1_arg_reg    <= small_arg;
            s1_sample_reg <= sample;
        end
    end

    assign res_valid    = res_valid_reg;
    assign change_flags = flags_reg;
    assign key_map      = map_reg;
    assign press_level  = press_reg;
    assign input_level  = input_reg;
    assign range_level  = range_reg;
    assign octave       = octave_reg;

endmodule

>>> hdl/kcc_port_checker.sv
// Port-level checks of the keyboard control conditioner, bound to its top level.
// Depends on kcc_pkg and keyboard_control_conditioner_core_macros.svh.
`include "keyboard_control_conditioner_core_macros.svh"

module kcc_port_checker
    import kcc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  logic [FLAG_W-1:0]    change_flags,
    input  logic [NUM_KEYS-1:0]  key_map,
    input  logic [ARG_W-1:0]     press_level,
    input  logic [LEVEL_W-1:0]   input_level,
    input  logic [LEVEL_W-1:0]   range_level,
    input  logic [OCT_W-1:0]     octave
);

    // A waiting result stays offered.
    `KCC_ASSERT_NEXT(a_res_held, clk, rst_n, res_valid && res_stall, res_valid)

    // A stalled result does not change.
    `KCC_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && res_stall, $stable(change_flags) && $stable(key_map) && $stable(press_level) && $stable(input_level) && $stable(range_level) && $stable(octave))

    // The request side only stalls behind a stalled result.
    `KCC_ASSERT_NOW(a_stall_cause, clk, rst_n, req_stall, res_valid && res_stall)

    // A taken request whose result slot is free in the next cycle shows a result.
    `KCC_ASSERT_NEXT(a_res_follows, clk, rst_n, (req_valid && !req_stall) ##1 !(res_valid && res_stall), res_valid)

endmodule

bind keyboard_control_conditioner_core kcc_port_checker #(.NUM_KEYS(NUM_KEYS)) u_port_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .change_flags (change_flags),
    .key_map      (key_map),
    .press_level  (press_level),
    .input_level  (input_level),
    .range_level  (range_level),
    .octave       (octave)
);
